FILE: rtl/rgc_pkg.sv
// Shared widths, constants and control types of the readability grade counter.
`timescale 1ns / 1ps
`default_nettype none

package rgc_pkg;

    // Field widths.
    localparam int CH_W    = 8;
    localparam int WORD_W  = 21;
    localparam int CNT_W   = 20;
    localparam int FRAC_W  = 16;
    localparam int GRADE_W = 41;

    // Longest text in characters; later characters are dropped and flagged.
    localparam int unsigned MAX_LEN = 1048575;

    // Counter limits.
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1);

    // Divider operands: a magnitude shifted left by the fraction width.
    localparam int DVD_W = WORD_W + FRAC_W;
    localparam int DVS_W = WORD_W;

    // Grade coefficients in Q16: 0.39, 11.8 and 15.59.
    localparam logic [14:0]        K_Q1     = 15'd25559;
    localparam logic [19:0]        K_Q2     = 20'd773325;
    localparam logic [GRADE_W-1:0] K_OFF    = GRADE_W'(1021706);
    localparam logic [GRADE_W-1:0] K_OFF_M1 = GRADE_W'(1021705);

    localparam int PROD_W = DVD_W + $bits(K_Q2);
    localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << FRAC_W) - 1);

    // Character codes with a role of their own.
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_PAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_FIN  = 8'b0000_0010,
        S_PREP = 8'b0000_0100,
        S_DIV1 = 8'b0000_1000,
        S_DIV2 = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_SUM  = 8'b0100_0000,
        S_LOAD = 8'b1000_0000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;        // a character transaction is accepted
        logic fin;         // count the held character against NUL
        logic prep;        // latch end-of-text operands, start the first division
        logic div2_start;  // keep the first quotient, start the second division
        logic mul;         // register both products
        logic sum;         // register the rounded sum
        logic load;        // load the result register and clear the counts
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/rgc_if.sv
// Input and result channel interfaces of the readability grade counter.
`timescale 1ns / 1ps
`default_nettype none

interface rgc_in_if;
    logic                       valid;
    logic                       ready;
    logic [rgc_pkg::CH_W-1:0]   ch;
    logic                       char_valid;
    logic                       last;

    modport source (output valid, output ch, output char_valid, output last, input ready);
    modport sink   (input valid, input ch, input char_valid, input last, output ready);
endinterface

interface rgc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rgc_pkg::WORD_W-1:0]  word_total;
    logic [rgc_pkg::CNT_W-1:0]          sentence_total;
    logic [rgc_pkg::CNT_W-1:0]          syllable_total;
    logic signed [rgc_pkg::GRADE_W-1:0] grade_q16;
    logic                               too_long;

    modport source (output valid, output word_total, output sentence_total,
                    output syllable_total, output grade_q16, output too_long,
                    input ready);
    modport sink   (input valid, input word_total, input sentence_total,
                    input syllable_total, input grade_q16, input too_long,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/rgc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rgc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [rgc_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [rgc_pkg::DVS_W-1:0]   i_divisor,
    output logic [rgc_pkg::DVD_W-1:0]        o_quotient,
    output logic                             o_done
);
    localparam int DVD_W   = rgc_pkg::DVD_W;
    localparam int DVS_W   = rgc_pkg::DVS_W;
    localparam int DC_W    = $clog2(DVD_W);
    localparam logic [DC_W-1:0] CNT_LAST = DC_W'(DVD_W - 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DC_W-1:0]  r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fit;

    // The dividend shifts out of the top of r_quo while quotient bits enter below.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[DVD_W-1]};
        fit    = trial >= {1'b0, r_dvs};
        diff   = trial - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_LAST;
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], fit};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

FILE: rtl/rgc_dp.sv
// Datapath: character counters, grade arithmetic and the result register.
`timescale 1ns / 1ps
`default_nettype none

module rgc_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [rgc_pkg::CH_W-1:0]      i_ch,
    input  wire rgc_pkg::t_cmd                 i_cmd,
    output rgc_pkg::t_sts                      o_sts,
    output logic signed [rgc_pkg::WORD_W-1:0]  o_word_total,
    output logic [rgc_pkg::CNT_W-1:0]          o_sentence_total,
    output logic [rgc_pkg::CNT_W-1:0]          o_syllable_total,
    output logic signed [rgc_pkg::GRADE_W-1:0] o_grade_q16,
    output logic                               o_too_long
);
    localparam int CH_W    = rgc_pkg::CH_W;
    localparam int WORD_W  = rgc_pkg::WORD_W;
    localparam int CNT_W   = rgc_pkg::CNT_W;
    localparam int FRAC_W  = rgc_pkg::FRAC_W;
    localparam int GRADE_W = rgc_pkg::GRADE_W;
    localparam int DVD_W   = rgc_pkg::DVD_W;
    localparam int DVS_W   = rgc_pkg::DVS_W;
    localparam int PROD_W  = rgc_pkg::PROD_W;

    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_cntrl(input logic [CH_W-1:0] c);
        return (c < 8'h20) || (c == 8'h7F);
    endfunction

    function automatic logic is_alnum(input logic [CH_W-1:0] c);
        return ((c >= "0") && (c <= "9")) || ((c >= "a") && (c <= "z")) ||
               ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_vowel(input logic [CH_W-1:0] c);
        return (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u") ||
               (c == "A") || (c == "E") || (c == "I") || (c == "O") || (c == "U");
    endfunction

    // Running counts of the current text.
    logic [CH_W-1:0]    r_held, n_held;
    logic               r_held_valid, n_held_valid;
    logic               r_char_seen, n_char_seen;
    logic               r_ovf, n_ovf;
    logic [WORD_W-1:0]  r_word_acc, n_word_acc;
    logic [CNT_W-1:0]   r_sent_acc, n_sent_acc;
    logic [CNT_W-1:0]   r_syl_acc, n_syl_acc;
    logic [CNT_W-1:0]   r_char_total, n_char_total;

    // End-of-text operands and arithmetic registers.
    logic [WORD_W-1:0]  r_words;
    logic [CNT_W-1:0]   r_sents;
    logic [CNT_W-1:0]   r_syls;
    logic [DVS_W-1:0]   r_wmag;
    logic               r_neg;
    logic               r_zero;
    logic [DVD_W-1:0]   r_q1;
    logic [PROD_W-1:0]  r_p1;
    logic [PROD_W-1:0]  r_p2;
    logic [PROD_W-1:0]  r_sum;

    // Result register.
    logic [WORD_W-1:0]  r_out_words;
    logic [CNT_W-1:0]   r_out_sents;
    logic [CNT_W-1:0]   r_out_syls;
    logic [GRADE_W-1:0] r_out_grade;
    logic               r_out_ovf;

    logic [CH_W-1:0]    look;
    logic               drop;
    logic               do_count;
    logic               inc_w;
    logic               dec_w;
    logic [WORD_W:0]    w_step;
    logic [WORD_W:0]    w_sum;
    logic [WORD_W-1:0]  words_eff;
    logic [CNT_W-1:0]   sents_eff;
    logic [DVS_W-1:0]   w_mag;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic [DVD_W-1:0]   div_quo;
    logic               div_done;
    logic [GRADE_W-1:0] t_floor;
    logic [GRADE_W-1:0] grade;

    // The held character is counted against the new character, or against
    // NUL once the text has ended.
    always_comb begin
        look     = i_cmd.fin ? rgc_pkg::CH_NUL : i_ch;
        drop     = 32'(r_char_total) >= rgc_pkg::MAX_LEN;
        do_count = r_held_valid && ((i_cmd.take && !drop) || i_cmd.fin);
        inc_w    = (r_held == rgc_pkg::CH_PAREN) || (is_space(r_held) && is_alnum(look));
        dec_w    = is_space(r_held) && is_cntrl(look);
        w_step   = inc_w ? (WORD_W+1)'(1) : (dec_w ? '1 : '0);
        w_sum    = {r_word_acc[WORD_W-1], r_word_acc} + w_step;
    end

    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_char_seen  = r_char_seen;
        n_ovf        = r_ovf;
        n_word_acc   = r_word_acc;
        n_sent_acc   = r_sent_acc;
        n_syl_acc    = r_syl_acc;
        n_char_total = r_char_total;
        if (i_cmd.load) begin
            n_held       = '0;
            n_held_valid = 1'b0;
            n_char_seen  = 1'b0;
            n_ovf        = 1'b0;
            n_word_acc   = rgc_pkg::WORD_ONE;
            n_sent_acc   = '0;
            n_syl_acc    = '0;
            n_char_total = '0;
        end else begin
            if (i_cmd.take) begin
                if (drop) begin
                    n_ovf = 1'b1;
                end else begin
                    n_held       = i_ch;
                    n_held_valid = 1'b1;
                    n_char_seen  = 1'b1;
                    if (r_char_total != rgc_pkg::CNT_MAX) begin
                        n_char_total = r_char_total + 1'b1;
                    end
                end
            end
            if (do_count) begin
                if (w_sum[WORD_W] != w_sum[WORD_W-1]) begin
                    n_word_acc = w_sum[WORD_W] ? rgc_pkg::WORD_MIN : rgc_pkg::WORD_MAX;
                end else begin
                    n_word_acc = w_sum[WORD_W-1:0];
                end
                if (((r_held == rgc_pkg::CH_BANG) || (r_held == rgc_pkg::CH_QUEST) ||
                     (r_held == rgc_pkg::CH_DOT)) && (r_sent_acc != rgc_pkg::CNT_MAX)) begin
                    n_sent_acc = r_sent_acc + 1'b1;
                end
                if (is_vowel(r_held) && !is_vowel(look) &&
                    (r_syl_acc != rgc_pkg::CNT_MAX)) begin
                    n_syl_acc = r_syl_acc + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_held_valid <= 1'b0;
            r_char_seen  <= 1'b0;
            r_ovf        <= 1'b0;
            r_word_acc   <= rgc_pkg::WORD_ONE;
            r_sent_acc   <= '0;
            r_syl_acc    <= '0;
            r_char_total <= '0;
        end else begin
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_char_seen  <= n_char_seen;
            r_ovf        <= n_ovf;
            r_word_acc   <= n_word_acc;
            r_sent_acc   <= n_sent_acc;
            r_syl_acc    <= n_syl_acc;
            r_char_total <= n_char_total;
        end
    end

    // An empty text has no words; a text with words has at least one sentence.
    always_comb begin
        words_eff = r_char_seen ? r_word_acc : '0;
        sents_eff = ((words_eff != '0) && (r_sent_acc == '0)) ? CNT_W'(1) : r_sent_acc;
        w_mag     = words_eff[WORD_W-1] ? DVS_W'(-words_eff) : DVS_W'(words_eff);
        div_start = i_cmd.prep || i_cmd.div2_start;
        if (i_cmd.prep) begin
            div_dvd = {w_mag, {FRAC_W{1'b0}}};
            div_dvs = DVS_W'(sents_eff);
        end else begin
            div_dvd = DVD_W'({r_syls, {FRAC_W{1'b0}}});
            div_dvs = r_wmag;
        end
    end

    rgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_quotient (div_quo),
        .o_done     (div_done)
    );

    assign o_sts.div_done = div_done;

    // Both quotients carry the sign of the word count, so the products are
    // formed on magnitudes. A negative sum is floored by rounding its
    // magnitude up before the shift and then negating.
    always_comb begin
        t_floor = r_sum[PROD_W-1:FRAC_W];
        if (r_zero) begin
            grade = '0;
        end else if (r_neg) begin
            grade = ~t_floor - rgc_pkg::K_OFF_M1;
        end else begin
            grade = t_floor - rgc_pkg::K_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_words <= words_eff;
            r_sents <= sents_eff;
            r_syls  <= r_syl_acc;
            r_wmag  <= w_mag;
            r_neg   <= words_eff[WORD_W-1];
            r_zero  <= (words_eff == '0);
        end
        if (i_cmd.div2_start) begin
            r_q1 <= div_quo;
        end
        if (i_cmd.mul) begin
            r_p1 <= PROD_W'(r_q1) * PROD_W'(rgc_pkg::K_Q1);
            r_p2 <= PROD_W'(div_quo) * PROD_W'(rgc_pkg::K_Q2);
        end
        if (i_cmd.sum) begin
            r_sum <= r_p1 + r_p2 + (r_neg ? rgc_pkg::ROUND_BIAS : '0);
        end
        if (i_cmd.load) begin
            r_out_words <= r_words;
            r_out_sents <= r_sents;
            r_out_syls  <= r_syls;
            r_out_grade <= grade;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_word_total     = r_out_words;
    assign o_sentence_total = r_out_sents;
    assign o_syllable_total = r_out_syls;
    assign o_grade_q16      = r_out_grade;
    assign o_too_long       = r_out_ovf;

endmodule

`default_nettype wire

FILE: rtl/rgc_ctrl.sv
// Controller: sequences counting, the end-of-text arithmetic and the result handshake.
`timescale 1ns / 1ps
`default_nettype none

module rgc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_char_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rgc_pkg::t_cmd      o_cmd,
    input  wire rgc_pkg::t_sts i_sts
);
    rgc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            in_acc;
    logic            out_free;

    assign o_in_ready = (r_state == rgc_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            rgc_pkg::S_IDLE: begin
                o_cmd.take = in_acc && i_in_char_valid;
                if (in_acc && i_in_last) begin
                    n_state = rgc_pkg::S_FIN;
                end
            end
            rgc_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = rgc_pkg::S_PREP;
            end
            rgc_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = rgc_pkg::S_DIV1;
            end
            rgc_pkg::S_DIV1: begin
                if (i_sts.div_done) begin
                    o_cmd.div2_start = 1'b1;
                    n_state          = rgc_pkg::S_DIV2;
                end
            end
            rgc_pkg::S_DIV2: begin
                if (i_sts.div_done) begin
                    n_state = rgc_pkg::S_MUL;
                end
            end
            rgc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = rgc_pkg::S_SUM;
            end
            rgc_pkg::S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = rgc_pkg::S_LOAD;
            end
            rgc_pkg::S_LOAD: begin
                // Wait until the previous result has left the result register.
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = rgc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rgc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rgc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_last_ends_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> (r_state == rgc_pkg::S_FIN))
        else $error("end-of-text transaction did not start the final count");

    a_done_in_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> ((r_state == rgc_pkg::S_DIV1) || (r_state == rgc_pkg::S_DIV2)))
        else $error("divider finished outside a division state");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_cmd.load)
        else $error("pending result overwritten");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (o_out_valid && (r_state == rgc_pkg::S_IDLE)))
        else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: rtl/readability_grade_counter.sv
// Top level of the readability grade counter: controller, datapath and channels.
// Characters are taken one per cycle while the counter is idle; a transaction without last yields no result.
// A transaction with last gives its result after two divisions in the shared restoring
// divider (37 quotient bits each) and the fin, prep, mul, sum and load steps.
// Input is held off meanwhile; an unread result stalls only the next text's load step.
// Synchronous active-low reset clears the counts and the handshake state at once.
`timescale 1ns / 1ps
`default_nettype none

module readability_grade_counter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rgc_in_if.sink     i_in,
    rgc_out_if.source  o_out
);
    rgc_pkg::t_cmd cmd;
    rgc_pkg::t_sts sts;

    rgc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in.valid),
        .i_in_char_valid (i_in.char_valid),
        .i_in_last       (i_in.last),
        .o_in_ready      (i_in.ready),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_cmd           (cmd),
        .i_sts           (sts)
    );

    rgc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ch             (i_in.ch),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_word_total     (o_out.word_total),
        .o_sentence_total (o_out.sentence_total),
        .o_syllable_total (o_out.syllable_total),
        .o_grade_q16      (o_out.grade_q16),
        .o_too_long       (o_out.too_long)
    );

endmodule

`default_nettype wire

FILE: test/tb_readability_grade_counter.sv
// Self-checking testbench for the readability grade counter with a grade scoreboard.
`timescale 1ns / 1ps

module tb_readability_grade_counter;

    localparam int          WORD_HI      = (1 << (rgc_pkg::WORD_W - 1)) - 1;
    localparam int          WORD_LO      = -(1 << (rgc_pkg::WORD_W - 1));
    localparam int unsigned CNT_LIMIT    = (1 << rgc_pkg::CNT_W) - 1;
    // Grade coefficients 0.39, 11.8 and 15.59, each rounded to Q16.
    localparam longint      GRADE_K_WPS  = 25559;
    localparam longint      GRADE_K_SPW  = 773325;
    localparam longint      GRADE_OFFSET = 1021706;
    localparam int          RANDOM_ITEMS = 700;
    localparam int          MIN_TEXTS    = 40;
    localparam int          TAIL_CYCLES  = 120;
    localparam int unsigned CYCLE_LIMIT  = 4000000;

    typedef struct packed {
        logic signed [rgc_pkg::WORD_W-1:0]  words;
        logic [rgc_pkg::CNT_W-1:0]          sentences;
        logic [rgc_pkg::CNT_W-1:0]          syllables;
        logic signed [rgc_pkg::GRADE_W-1:0] grade;
        logic                               too_long;
    } t_grade_result;

    class t_grade_scoreboard;
        t_grade_result expected_q[$];
        int unsigned   mismatches;
        int unsigned   results_seen;
        logic [7:0]    held_ch;
        bit            held;
        bit            seen;
        int            word_cnt;
        int unsigned   sent_cnt;
        int unsigned   syl_cnt;
        int unsigned   char_cnt;
        bit            dropped;

        function new();
            mismatches   = 0;
            results_seen = 0;
            clear_text();
        endfunction

        function void clear_text();
            held_ch  = rgc_pkg::CH_NUL;
            held     = 1'b0;
            seen     = 1'b0;
            word_cnt = 1;
            sent_cnt = 0;
            syl_cnt  = 0;
            char_cnt = 0;
            dropped  = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function bit is_ctrl(logic [7:0] c);
            return c < 8'h20 || c == 8'h7F;
        endfunction

        function bit is_alnum(logic [7:0] c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit is_vowel(logic [7:0] c);
            logic [7:0] lc;
            lc = c | 8'h20;
            return lc == "a" || lc == "e" || lc == "i" || lc == "o" || lc == "u";
        endfunction

        function void bump_words(int d);
            int v;
            v = word_cnt + d;
            if (v > WORD_HI) v = WORD_HI;
            if (v < WORD_LO) v = WORD_LO;
            word_cnt = v;
        endfunction

        // Counts character c with the character that follows it as lookahead.
        function void count_pair(logic [7:0] c, logic [7:0] nxt);
            int d;
            if (c == rgc_pkg::CH_PAREN) begin
                bump_words(1);
            end else if (is_blank(c)) begin
                d = 1;
                if (!is_alnum(nxt)) d--;
                if (is_ctrl(nxt)) d--;
                bump_words(d);
            end
            if ((c == rgc_pkg::CH_BANG || c == rgc_pkg::CH_QUEST || c == rgc_pkg::CH_DOT) &&
                sent_cnt < CNT_LIMIT)
                sent_cnt++;
            if (is_vowel(c) && !is_vowel(nxt) && syl_cnt < CNT_LIMIT)
                syl_cnt++;
        endfunction

        function void take_char(logic [7:0] c);
            if (char_cnt >= rgc_pkg::MAX_LEN) begin
                dropped = 1'b1;
                return;
            end
            if (held) count_pair(held_ch, c);
            held_ch = c;
            held    = 1'b1;
            seen    = 1'b1;
            if (char_cnt < CNT_LIMIT) char_cnt++;
        endfunction

        function void note_input(logic [7:0] c, logic cv, logic lst);
            longint        w, s, y, q1, q2, g;
            t_grade_result r;
            if (cv) take_char(c);
            if (!lst) return;
            if (held) count_pair(held_ch, rgc_pkg::CH_NUL);
            w = seen ? longint'(word_cnt) : 0;
            s = sent_cnt;
            if (w != 0 && s == 0) s = 1;
            y = syl_cnt;
            g = 0;
            if (s != 0 && w != 0) begin
                q1 = (w * 65536) / s;
                q2 = (y * 65536) / w;
                g  = ((GRADE_K_WPS * q1 + GRADE_K_SPW * q2) >>> 16) - GRADE_OFFSET;
            end
            r.words     = w[rgc_pkg::WORD_W-1:0];
            r.sentences = s[rgc_pkg::CNT_W-1:0];
            r.syllables = y[rgc_pkg::CNT_W-1:0];
            r.grade     = g[rgc_pkg::GRADE_W-1:0];
            r.too_long  = dropped;
            expected_q.push_back(r);
            clear_text();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string field, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                          results_seen, field, got, want));
        endtask

        task check_result(t_grade_result got);
            t_grade_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result transaction with no text pending");
                return;
            end
            want = expected_q.pop_front();
            check_field("word_total", got.words, want.words);
            check_field("sentence_total", got.sentences, want.sentences);
            check_field("syllable_total", got.syllables, want.syllables);
            check_field("grade_q16", got.grade, want.grade);
            check_field("too_long", got.too_long, want.too_long);
            results_seen++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned cycle_count = 0;

    rgc_in_if  in_ch();
    rgc_out_if out_ch();

    readability_grade_counter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_grade_scoreboard sb;
    logic [7:0]        text_buf[$];
    bit                pace_on     = 1'b0;
    int                burst_left  = 0;
    int                text_items  = 0;
    int                texts_done  = 0;
    int                rx_hold     = 0;
    int                rx_mode     = 0;
    logic [7:0]        rx_phase    = 8'd0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result receiver: switches among no stalls, short stalls and long stalls.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else begin
                rx_phase <= rx_phase + 8'd1;
                if (rx_phase == 8'd0) rx_mode = $urandom_range(0, 2);
                if (rx_hold != 0) begin
                    out_ch.ready <= 1'b0;
                    rx_hold = rx_hold - 1;
                end else if (rx_mode == 1 && $urandom_range(0, 2) == 0) begin
                    out_ch.ready <= 1'b0;
                    rx_hold = $urandom_range(0, 2);
                end else if (rx_mode == 2 && $urandom_range(0, 7) == 0) begin
                    out_ch.ready <= 1'b0;
                    rx_hold = $urandom_range(5, 40);
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_grade_result got;
        if (i_rst_n && in_ch.valid && in_ch.ready)
            sb.note_input(in_ch.ch, in_ch.char_valid, in_ch.last);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.words     = out_ch.word_total;
            got.sentences = out_ch.sentence_total;
            got.syllables = out_ch.syllable_total;
            got.grade     = out_ch.grade_q16;
            got.too_long  = out_ch.too_long;
            sb.check_result(got);
        end
    end

    // Drives one input transaction and returns at the edge where it is accepted.
    task automatic send_item(input logic [rgc_pkg::CH_W-1:0] c, input logic cv,
                             input logic lst);
        int gap;
        if (pace_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(1, 12);
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        in_ch.valid      <= 1'b1;
        in_ch.ch         <= c;
        in_ch.char_valid <= cv;
        in_ch.last       <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Sends text_buf, with last on the final character or on a separate end-only transaction.
    task automatic send_text(input bit end_only);
        int i;
        for (i = 0; i < text_buf.size(); i++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(text_buf[i], 1'b1, !end_only && (i == text_buf.size() - 1));
            text_items++;
        end
        if (end_only || text_buf.size() == 0) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            text_items++;
        end
        texts_done++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic load_text(input string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    // Mostly sentences of random words; the rest is raw byte noise or an empty text.
    task automatic build_random_text();
        int         kind, n, nw, len, w, k;
        logic [7:0] c;
        text_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            return;
        end else if (kind <= 2) begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 31));
                else c = 8'($urandom_range(0, 255));
                text_buf.push_back(c);
            end
            return;
        end
        nw = $urandom_range(1, 6);
        for (w = 0; w < nw; w++) begin
            if ($urandom_range(0, 7) == 0) text_buf.push_back(rgc_pkg::CH_PAREN);
            len = $urandom_range(1, 7);
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) < 4) begin
                    case ($urandom_range(0, 4))
                        0: c = "a";
                        1: c = "e";
                        2: c = "i";
                        3: c = "o";
                        default: c = "u";
                    endcase
                end else if ($urandom_range(0, 9) == 0) begin
                    c = 8'($urandom_range(8'h30, 8'h39));
                end else begin
                    c = 8'($urandom_range(8'h61, 8'h7A));
                end
                if ($urandom_range(0, 3) == 0 && c >= 8'h61) c = c & 8'hDF;
                text_buf.push_back(c);
            end
            if ($urandom_range(0, 7) == 0) text_buf.push_back(")");
            if (w == nw - 1 || $urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(rgc_pkg::CH_DOT);
                    1: text_buf.push_back(rgc_pkg::CH_BANG);
                    2: text_buf.push_back(rgc_pkg::CH_QUEST);
                    default: text_buf.push_back(",");
                endcase
            end
            if (w != nw - 1 || $urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 7))
                    0: text_buf.push_back(8'h09);
                    1: text_buf.push_back(8'h0A);
                    2: begin
                        text_buf.push_back(8'h20);
                        text_buf.push_back(8'h20);
                    end
                    3: begin
                        text_buf.push_back(8'h20);
                        text_buf.push_back(8'h0D);
                    end
                    default: text_buf.push_back(8'h20);
                endcase
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.ch         <= '0;
        in_ch.char_valid <= 1'b0;
        in_ch.last       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pace_on = 1'b1;
        // Empty text.
        text_buf.delete();
        send_text(1'b1);
        // A lone vowel: one word, one syllable, sentence count forced to one.
        load_text("a");
        send_text(1'b0);
        // A NUL character inside the text does not end it.
        text_buf.delete();
        text_buf.push_back(rgc_pkg::CH_NUL);
        text_buf.push_back("e");
        send_text(1'b0);
        // Spaces only: the word count falls back to zero and the grade is zero.
        load_text("  ");
        send_text(1'b0);
        // Blanks before control bytes drive the word count negative.
        load_text(" \t\t");
        send_text(1'b0);
        load_text("(A x)! Ou? .");
        send_text(1'b1);
        // Bytes outside every class but 7F, which is a control byte.
        text_buf.delete();
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h7F);
        text_buf.push_back(8'h80);
        send_text(1'b1);
        drain_results();

        text_items = 0;
        texts_done = 0;
        while (text_items < RANDOM_ITEMS || texts_done < MIN_TEXTS) begin
            pace_on = ($urandom_range(0, 3) != 0);
            build_random_text();
            send_text(1'($urandom_range(0, 1)));
            if (texts_done % 12 == 0) drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
